/* rtl/core/divider_and_reloading_timer_macros.svh */
`ifndef DIVIDER_AND_RELOADING_TIMER_MACROS_SVH
`define DIVIDER_AND_RELOADING_TIMER_MACROS_SVH

// same-cycle implication
`define DART_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dart_pkg.sv */
package dart_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  localparam logic [15:0] ADDR_DIV = 16'hFF04;
  localparam logic [15:0] ADDR_CNT = 16'hFF05;
  localparam logic [15:0] ADDR_MOD = 16'hFF06;
  localparam logic [15:0] ADDR_CTL = 16'hFF07;

  localparam logic [7:0] CTL_READ_SET = 8'hF8;
  localparam int         CTL_EN_BIT   = 2;
  localparam logic [7:0] CNT_MAX      = 8'hFF;

  localparam int SUB_W = 11;

  typedef struct packed {
    logic             more;
    logic [SUB_W-1:0] sub;
    logic [7:0]       cnt;
    logic             wrap;
  } step_t;

  function automatic logic [SUB_W-1:0] period_of(input logic [1:0] sel);
    logic [SUB_W-1:0] p;
    unique case (sel)
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      2'd3:    p = 11'd256;
      default: p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/dart_step.sv */
module dart_step (
  input  logic [dart_pkg::SUB_W-1:0] sub,
  input  logic [1:0]                 period_sel,
  input  logic [7:0]                 cnt,
  input  logic [7:0]                 modulo,
  output dart_pkg::step_t            step
);

  logic [dart_pkg::SUB_W-1:0] period;

  // one period drained per use: compare, subtract and counter bump
  always_comb begin
    period    = dart_pkg::period_of(period_sel);
    step.more = (sub >= period);
    step.sub  = sub - period;
    step.wrap = (cnt == dart_pkg::CNT_MAX);
    step.cnt  = step.wrap ? modulo : cnt + 8'd1;
  end

endmodule

/* rtl/core/divider_and_reloading_timer.sv */
// Four-register timer (divider 0xFF04, counter 0xFF05, modulo 0xFF06, control 0xFF07)
// driven by request items on the input stream: tick, bus read or bus write. One
// request is in flight at a time. A read or write, or a tick with the counter
// disabled, goes from acceptance (idle) to the hand-off to the output register (done)
// before the next request can be taken; the hand-off waits for the output register to
// be free. An enabled tick first runs N counter increments in the run state: a
// single shared compare/subtract/increment unit drains one timer period per cycle,
// and a final step finds the sub-count below a period. N is at most 16 for the
// largest tick at the shortest period, and up to 79 right after the period is
// shortened with a large held sub-count. The result register lets the next request
// be accepted while the previous result is still waiting.
module divider_and_reloading_timer #(
  parameter int TICK_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // addr[15:0], write_data[23:16], tick_cycles[31:24]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // read_data[7:0], timer_irq[8], zero[15:9]
);

  localparam int UsedBits = (TICK_BITS < 8) ? TICK_BITS : 8;

  dart_pkg::state_t state_r, state_nxt;

  logic [7:0]  div_r, div_nxt;
  logic [7:0]  div_sub_r, div_sub_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  mod_r, mod_nxt;
  logic [2:0]  ctl_r, ctl_nxt;
  logic [9:0]  cnt_sub_r, cnt_sub_nxt;
  logic [dart_pkg::SUB_W-1:0] sub_r, sub_nxt;
  logic        irq_r, irq_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic [15:0]         addr;
  logic [7:0]          wdata;
  logic [UsedBits-1:0] cyc;
  logic [8:0]          div_acc;
  logic                accept;
  dart_pkg::step_t     step;

  assign addr  = in_tdata[15:0];
  assign wdata = in_tdata[23:16];
  assign cyc   = in_tdata[24 +: UsedBits];

  assign in_tready  = (state_r == dart_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  dart_step u_step (
    .sub        (sub_r),
    .period_sel (ctl_r[1:0]),
    .cnt        (cnt_r),
    .modulo     (mod_r),
    .step       (step)
  );

  always_comb begin
    state_nxt     = state_r;
    div_nxt       = div_r;
    div_sub_nxt   = div_sub_r;
    cnt_nxt       = cnt_r;
    mod_nxt       = mod_r;
    ctl_nxt       = ctl_r;
    cnt_sub_nxt   = cnt_sub_r;
    sub_nxt       = sub_r;
    irq_nxt       = irq_r;
    rd_nxt        = rd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    div_acc       = 9'(div_sub_r) + 9'(cyc);

    unique case (state_r)
      dart_pkg::ST_IDLE: begin
        if (accept) begin
          irq_nxt   = 1'b0;
          rd_nxt    = 8'd0;
          state_nxt = dart_pkg::ST_DONE;
          unique case (in_tuser)
            dart_pkg::FUNC_TICK: begin
              div_nxt     = div_r + 8'(div_acc[8]);
              div_sub_nxt = div_acc[7:0];
              if (ctl_r[dart_pkg::CTL_EN_BIT]) begin
                sub_nxt   = 11'(cnt_sub_r) + 11'(cyc);
                state_nxt = dart_pkg::ST_RUN;
              end
            end
            dart_pkg::FUNC_READ: begin
              priority if (addr == dart_pkg::ADDR_DIV) rd_nxt = div_r;
              else if (addr == dart_pkg::ADDR_CNT) rd_nxt = cnt_r;
              else if (addr == dart_pkg::ADDR_MOD) rd_nxt = mod_r;
              else if (addr == dart_pkg::ADDR_CTL) rd_nxt = {5'd0, ctl_r} | dart_pkg::CTL_READ_SET;
              else rd_nxt = 8'd0;
            end
            dart_pkg::FUNC_WRITE: begin
              priority if (addr == dart_pkg::ADDR_DIV) begin
                div_nxt     = 8'd0;
                div_sub_nxt = 8'd0;
              end else if (addr == dart_pkg::ADDR_CNT) begin
                cnt_nxt = wdata;
              end else if (addr == dart_pkg::ADDR_MOD) begin
                mod_nxt = wdata;
              end else if (addr == dart_pkg::ADDR_CTL) begin
                ctl_nxt = wdata[2:0];
              end else begin
                ctl_nxt = ctl_r;
              end
            end
            default: begin
              rd_nxt = 8'd0;
            end
          endcase
        end
      end
      dart_pkg::ST_RUN: begin
        if (step.more) begin
          sub_nxt = step.sub;
          cnt_nxt = step.cnt;
          irq_nxt = irq_r | step.wrap;
        end else begin
          cnt_sub_nxt = sub_r[9:0];
          state_nxt   = dart_pkg::ST_DONE;
        end
      end
      dart_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, irq_r, rd_r};
          state_nxt     = dart_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dart_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dart_pkg::ST_IDLE;
      div_r       <= 8'd0;
      div_sub_r   <= 8'd0;
      cnt_r       <= 8'd0;
      mod_r       <= 8'd0;
      ctl_r       <= 3'd0;
      cnt_sub_r   <= 10'd0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_r       <= div_nxt;
      div_sub_r   <= div_sub_nxt;
      cnt_r       <= cnt_nxt;
      mod_r       <= mod_nxt;
      ctl_r       <= ctl_nxt;
      cnt_sub_r   <= cnt_sub_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r      <= sub_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* rtl/core/dart_checker.sv */
`include "divider_and_reloading_timer_macros.svh"

module dart_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // one request in flight at a time
  `DART_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready right after accept")

  // stalled result holds
  `DART_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // padding stays zero
  `DART_ASSERT_NOW(a_out_pad, clk, rst_n, out_tvalid, out_tdata[15:9] == 7'd0, "nonzero padding")

  // an interrupt only comes from a tick, which reads nothing
  `DART_ASSERT_NOW(a_irq_no_data, clk, rst_n, out_tvalid && out_tdata[8], out_tdata[7:0] == 8'd0, "irq with read data")

endmodule

bind divider_and_reloading_timer dart_checker u_dart_checker (.*);

/* tb/sv/divider_and_reloading_timer_test.sv */
module divider_and_reloading_timer_test;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // addr[15:0], write_data[23:16], tick_cycles[31:24]
  logic [1:0]  in_tuser = '0;    // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // read_data[7:0], timer_irq[8], zero[15:9]

  // predicted register state
  logic [7:0] div_q;
  logic [7:0] div_sub_q;
  logic [7:0] cnt_q;
  logic [7:0] mod_q;
  logic [2:0] ctl_q;
  logic [9:0] cnt_sub_q;

  timer_result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_other = 0;
  int n_irqs = 0;

  divider_and_reloading_timer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic timer_result_t predict_timer_result(input logic [1:0] func,
                                                         input logic [15:0] addr,
                                                         input logic [7:0] wdata,
                                                         input logic [7:0] cycles);
    timer_result_t r;
    int acc;
    int sub;
    int period;
    r = '0;
    if (func == dart_pkg::FUNC_TICK) begin
      acc = div_sub_q + cycles;
      div_q = div_q + 8'(acc >> 8);
      div_sub_q = acc[7:0];
      if (ctl_q[2]) begin
        case (ctl_q[1:0])
          2'd1: period = 16;
          2'd2: period = 64;
          2'd3: period = 256;
          default: period = 1024;
        endcase
        sub = cnt_sub_q + cycles;
        while (sub >= period) begin
          sub = sub - period;
          if (cnt_q == 8'hFF) begin
            cnt_q = mod_q;
            r.timer_irq = 1'b1;
          end else begin
            cnt_q = cnt_q + 8'd1;
          end
        end
        cnt_sub_q = sub[9:0];
      end
    end else if (func == dart_pkg::FUNC_READ) begin
      case (addr)
        dart_pkg::ADDR_DIV: r.read_data = div_q;
        dart_pkg::ADDR_CNT: r.read_data = cnt_q;
        dart_pkg::ADDR_MOD: r.read_data = mod_q;
        dart_pkg::ADDR_CTL: r.read_data = {5'h1F, ctl_q};
        default: r.read_data = 8'h00;
      endcase
    end else if (func == dart_pkg::FUNC_WRITE) begin
      case (addr)
        dart_pkg::ADDR_DIV: begin
          div_q = 8'h00;
          div_sub_q = 8'h00;
        end
        dart_pkg::ADDR_CNT: cnt_q = wdata;
        dart_pkg::ADDR_MOD: mod_q = wdata;
        dart_pkg::ADDR_CTL: ctl_q = wdata[2:0];
        default: ;
      endcase
    end
    return r;
  endfunction

  // called at a rising edge, returns at the edge where the request is taken
  task automatic send_request(input logic [1:0] func, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [7:0] cycles);
    timer_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {cycles, wdata, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_timer_result(func, addr, wdata, cycles);
    expected_results.push_back(r);
    if (r.timer_irq) n_irqs++;
    case (func)
      dart_pkg::FUNC_TICK: n_ticks++;
      dart_pkg::FUNC_READ: n_reads++;
      dart_pkg::FUNC_WRITE: n_writes++;
      default: n_other++;
    endcase
  endtask

  task automatic note_mismatch(input string what, input timer_result_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %0s: expected read_data %02h irq %0b, got tdata %04h",
               what, want.read_data, want.timer_irq, out_tdata);
  endtask

  // result checker
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[7:0] !== want.read_data)
          note_mismatch("read_data", want);
        else if (out_tdata[8] !== want.timer_irq)
          note_mismatch("timer_irq", want);
        else if (out_tdata[15:9] !== 7'd0)
          note_mismatch("padding", want);
      end
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles_left > 0) begin
      out_tready <= 1'b0;
      hold_cycles_left = hold_cycles_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic test_reset_values();
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_DIV, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CNT, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_MOD, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CTL, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_READ, 16'h0000, 8'hFF, 8'hFF);
    send_request(dart_pkg::FUNC_READ, 16'hFFFF, 8'h00, 8'h00);
  endtask

  task automatic test_counter_overflow();
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_MOD, 8'hFF, 8'h00);
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CNT, 8'hFE, 8'h00);
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CTL, 8'h05, 8'h00);
    // several reloads in one tick
    send_request(dart_pkg::FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CNT, 8'h00, 8'h00);
  endtask

  task automatic test_control_and_divider();
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CTL, 8'hF8, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CTL, 8'h00, 8'h00);
    // timer disabled, divider keeps running
    send_request(dart_pkg::FUNC_TICK, dart_pkg::ADDR_CNT, 8'h00, 8'hFF);
    send_request(dart_pkg::FUNC_TICK, 16'h0000, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_DIV, 8'hAB, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_DIV, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_WRITE, 16'h0000, 8'hFF, 8'h00);
    send_request(FUNC_UNUSED, dart_pkg::ADDR_CNT, 8'hFF, 8'hFF);
  endtask

  task automatic test_period_change();
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CTL, 8'h04, 8'h00);
    repeat (4) send_request(dart_pkg::FUNC_TICK, 16'h0000, 8'h00, 8'hFF);
    // a zero-cycle tick tests the held sub-count against the short period
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CTL, 8'h05, 8'h00);
    send_request(dart_pkg::FUNC_TICK, 16'h0000, 8'h00, 8'h00);
    send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CNT, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    int done;
    int pick;
    logic [1:0] func;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [7:0] cycles;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      addr = dart_pkg::ADDR_DIV + 16'($urandom_range(3));
      wdata = 8'($urandom_range(255));
      cycles = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) cycles = $urandom_range(1) ? 8'hFF : 8'h00;
      if (pick < 45) begin
        func = dart_pkg::FUNC_TICK;
        if ($urandom_range(1)) addr = 16'($urandom_range(65535));
      end else if (pick < 65) begin
        func = dart_pkg::FUNC_WRITE;
        if (addr == dart_pkg::ADDR_CTL && $urandom_range(3) != 0) wdata[2] = 1'b1;
        if (addr == dart_pkg::ADDR_CNT && $urandom_range(1))
          wdata = 8'($urandom_range(255, 240));
      end else if (pick < 85) begin
        func = dart_pkg::FUNC_READ;
      end else if (pick < 93) begin
        func = $urandom_range(1) ? dart_pkg::FUNC_READ : dart_pkg::FUNC_WRITE;
        addr = 16'($urandom_range(65535));
      end else begin
        func = FUNC_UNUSED;
        addr = 16'($urandom_range(65535));
      end
      send_request(func, addr, wdata, cycles);
      done++;
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles_left = HOLD_CYCLES;
    send_request(dart_pkg::FUNC_WRITE, dart_pkg::ADDR_CTL, 8'h05, 8'h00);
    repeat (30) begin
      send_request(dart_pkg::FUNC_TICK, 16'h0000, 8'h00, 8'($urandom_range(255)));
      send_request(dart_pkg::FUNC_READ, dart_pkg::ADDR_CNT, 8'h00, 8'h00);
    end
  endtask

  initial begin
    div_q = '0;
    div_sub_q = '0;
    cnt_q = '0;
    mod_q = '0;
    ctl_q = '0;
    cnt_sub_q = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_counter_overflow();
    test_control_and_divider();
    test_period_change();
    test_random_traffic(170, 0, 0);
    test_random_traffic(160, 85, 0);
    test_random_traffic(160, 0, 85);
    test_random_traffic(160, 13, 13);
    test_output_backpressure();

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks, %0d reads, %0d writes, %0d unused or noise requests",
             n_ticks, n_reads, n_writes, n_other);
    $display("%0d results checked, %0d with timer interrupt, %0d mismatches",
             results_seen, n_irqs, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* divider_and_reloading_timer.f */
+incdir+rtl/core
rtl/core/dart_pkg.sv
rtl/core/dart_step.sv
rtl/core/divider_and_reloading_timer.sv
rtl/core/dart_checker.sv
tb/sv/divider_and_reloading_timer_test.sv
